// ===== design/vsc_pkg.sv =====
// Shared types and constants for the vertex-sphere contact unit.
`default_nettype none
package vsc_pkg;
   localparam int MaxNormals = 8;
   localparam int FracBits   = 16;
   localparam int IdxW       = $clog2(MaxNormals);
   localparam int CntW       = $clog2(MaxNormals + 1);

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_QREV  = 2'd3
   } action_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch request beat
      logic load_store;  // write normal at count
      logic clear_store;
      logic dot_step;    // dot product of current normal
      logic dot_check;   // test registered dot sign
      logic sq_step;     // one squared component
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic div_done;
      logic cp_step;     // contact offset product
      logic emit;
      logic emit_zero;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic dot_neg;
      logic dots_left;
      logic far;
      logic no_hit;
      logic sqrt_last;
      logic div_last;
      logic axis_last;
      logic flat;
      logic [1:0] action;
   } stat_type;
endpackage
`default_nettype wire

// ===== design/vsc_datapath.sv =====
// Datapath: normal store, dot products, sqrt, divider, contact math.
`default_nettype none
module vsc_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vsc_pkg::cmd_type     cmd,
   output vsc_pkg::stat_type         stat,
   input  wire logic [1:0]           req_action,
   input  wire logic signed [31:0]   req_vertex_x,
   input  wire logic signed [31:0]   req_vertex_y,
   input  wire logic signed [31:0]   req_vertex_z,
   input  wire logic signed [31:0]   req_sphere_x,
   input  wire logic signed [31:0]   req_sphere_y,
   input  wire logic signed [31:0]   req_sphere_z,
   input  wire logic [30:0]          req_sphere_radius,
   input  wire logic                 req_vertex_flat,
   input  wire logic signed [31:0]   req_face_normal_x,
   input  wire logic signed [31:0]   req_face_normal_y,
   input  wire logic signed [31:0]   req_face_normal_z,
   output logic                      rsp_hit,
   output logic signed [31:0]        rsp_unit_normal_x,
   output logic signed [31:0]        rsp_unit_normal_y,
   output logic signed [31:0]        rsp_unit_normal_z,
   output logic [30:0]               rsp_depth,
   output logic signed [31:0]        rsp_contact_x,
   output logic signed [31:0]        rsp_contact_y,
   output logic signed [31:0]        rsp_contact_z,
   output logic [30:0]               rsp_radius_first,
   output logic [30:0]               rsp_radius_second
);
   localparam int IdxW = vsc_pkg::IdxW;
   localparam int CntW = vsc_pkg::CntW;
   localparam int QW   = 32 + vsc_pkg::FracBits; // dividend width

   logic [95:0]            store_mem [vsc_pkg::MaxNormals];
   logic [CntW-1:0]        count_ff;
   logic [CntW-1:0]        walk_ff, walk_in;
   logic [95:0]            nrm_ff;
   logic [95:0]            fn_ff;

   logic [1:0]             act_ff;
   logic                   flat_ff;
   logic signed [31:0]     vert_ff [3];
   logic signed [32:0]     off_ff  [3];
   logic [30:0]            rad_ff;
   logic [1:0]             axis_ff, axis_in;

   logic signed [65:0]     prod_ff [3];
   logic [63:0]            sumsq_ff;
   logic [63:0]            rem_ff, root_ff, bit_ff;
   logic [31:0]            dist_ff;
   logic [30:0]            dep_ff;
   logic [QW-1:0]          num_ff;
   logic [QW-1:0]          quo_ff;
   logic [32:0]            drem_ff;
   logic [6:0]             dcnt_ff;
   logic [30:0]            un_ff [3];
   logic [61:0]            cp_ff;

   logic signed [31:0]     nv [3];
   logic [31:0]            offm [3];
   logic [32:0]            mag_cur;
   logic [63:0]            trial;
   logic [33:0]            dsh;
   logic [30:0]            qsat;

   always_comb begin
      nv[0] = nrm_ff[95:64];
      nv[1] = nrm_ff[63:32];
      nv[2] = nrm_ff[31:0];
      for (int i = 0; i < 3; i++) begin
         offm[i] = off_ff[i][32] ? 32'(-off_ff[i]) : 32'(off_ff[i]);
      end
      mag_cur = off_ff[axis_ff][32] ? 33'(-off_ff[axis_ff]) : 33'(off_ff[axis_ff]);
      trial   = root_ff + bit_ff;
      dsh     = {drem_ff, num_ff[QW-1]};
      qsat    = (|quo_ff[QW-1:31]) ? 31'h7FFF_FFFF : quo_ff[30:0];
   end

   // store and count
   always_ff @(posedge clock) begin
      if (cmd.load_store && count_ff < CntW'(vsc_pkg::MaxNormals)) begin
         store_mem[count_ff[IdxW-1:0]] <= fn_ff;
      end
      nrm_ff <= store_mem[walk_in[IdxW-1:0]];
   end

   always_comb begin
      walk_in = walk_ff;
      if (cmd.capture)       walk_in = '0;
      else if (cmd.dot_step) walk_in = walk_ff + 1'b1;
      axis_in = axis_ff;
      if (cmd.capture || cmd.sqrt_init || cmd.div_done && axis_ff == 2'd2)
         axis_in = '0;
      else if (cmd.sq_step || cmd.div_done || cmd.cp_step) axis_in = axis_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         walk_ff  <= '0;
         axis_ff  <= '0;
      end else begin
         walk_ff <= walk_in;
         axis_ff <= axis_in;
         if (cmd.clear_store) count_ff <= '0;
         else if (cmd.load_store && count_ff < CntW'(vsc_pkg::MaxNormals))
            count_ff <= count_ff + 1'b1;
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         flat_ff  <= req_vertex_flat;
         rad_ff   <= req_sphere_radius;
         fn_ff    <= {req_face_normal_x, req_face_normal_y, req_face_normal_z};
         vert_ff[0] <= req_vertex_x;
         vert_ff[1] <= req_vertex_y;
         vert_ff[2] <= req_vertex_z;
         off_ff[0]  <= 33'(req_sphere_x) - 33'(req_vertex_x);
         off_ff[1]  <= 33'(req_sphere_y) - 33'(req_vertex_y);
         off_ff[2]  <= 33'(req_sphere_z) - 33'(req_vertex_z);
         sumsq_ff   <= '0;
      end
      if (cmd.dot_step) begin
         for (int i = 0; i < 3; i++) prod_ff[i] <= 66'(off_ff[i]) * 66'(nv[i]);
      end
      if (cmd.sq_step) sumsq_ff <= sumsq_ff + 64'(offm[axis_ff]) * 64'(offm[axis_ff]);
      if (cmd.sqrt_init) begin
         rem_ff  <= sumsq_ff;
         root_ff <= '0;
         bit_ff  <= 64'h4000_0000_0000_0000;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         dist_ff <= 32'(root_ff);
      end
      if (cmd.div_init) begin
         dist_ff <= 32'(root_ff);
         dep_ff  <= 31'(33'(rad_ff) - 33'(root_ff));
         num_ff  <= QW'(mag_cur) << vsc_pkg::FracBits;
         drem_ff <= '0;
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (34'(dist_ff) <= dsh && dist_ff != 0) begin
            drem_ff <= 33'(dsh - 34'(dist_ff));
            quo_ff  <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            drem_ff <= dsh[32:0];
            quo_ff  <= {quo_ff[QW-2:0], 1'b0};
         end
         num_ff  <= num_ff << 1;
         dcnt_ff <= dcnt_ff + 1'b1;
      end else if (cmd.div_done) begin
         un_ff[axis_ff] <= qsat;
         if (axis_ff != 2'd2) begin
            num_ff  <= QW'(off_ff[axis_ff+1][32] ? 33'(-off_ff[axis_ff+1])
                                                : 33'(off_ff[axis_ff+1])) << vsc_pkg::FracBits;
            drem_ff <= '0;
            quo_ff  <= '0;
            dcnt_ff <= '0;
         end
      end
      if (cmd.cp_step) cp_ff <= 62'(dep_ff) * 62'(un_ff[axis_ff]);
   end

   // result register; contact for the last axis formed on the emit cycle
   logic signed [31:0] cont_ff [3];
   logic signed [33:0] cdiff;
   logic [30:0]        tw;
   logic [1:0]         cax;
   always_comb begin
      cax   = axis_ff - 1'b1;
      cdiff = 34'(vert_ff[cax]) - (off_ff[cax][32] ? -34'(cp_ff >> (vsc_pkg::FracBits+1))
                                                  : 34'(cp_ff >> (vsc_pkg::FracBits+1)));
      tw    = rad_ff[30] ? 31'h7FFF_FFFF : {rad_ff[29:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (cmd.cp_step && axis_ff != 2'd0 || cmd.emit) begin
         if (cdiff > 34'sh7FFF_FFFF)       cont_ff[cax] <= 32'sh7FFF_FFFF;
         else if (cdiff < -34'sh8000_0000) cont_ff[cax] <= 32'sh8000_0000;
         else                              cont_ff[cax] <= 32'(cdiff);
      end
   end

   logic signed [31:0] sn [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sn[i] = off_ff[i][32] ? -$signed({1'b0, un_ff[i]}) : $signed({1'b0, un_ff[i]});
         if (act_ff == vsc_pkg::ACT_QREV) sn[i] = -sn[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_hit <= 1'b0;
      end else if (cmd.emit_zero) begin
         rsp_hit <= 1'b0;
      end else if (cmd.emit) begin
         rsp_hit <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_zero) begin
         rsp_unit_normal_x <= '0; rsp_unit_normal_y <= '0; rsp_unit_normal_z <= '0;
         rsp_depth <= '0;
         rsp_contact_x <= '0; rsp_contact_y <= '0; rsp_contact_z <= '0;
         rsp_radius_first <= '0; rsp_radius_second <= '0;
      end else if (cmd.emit) begin
         rsp_unit_normal_x <= sn[0];
         rsp_unit_normal_y <= sn[1];
         rsp_unit_normal_z <= sn[2];
         rsp_depth         <= dep_ff;
         rsp_contact_x     <= cont_ff[0];
         rsp_contact_y     <= cont_ff[1];
         rsp_contact_z     <= (cdiff > 34'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                              (cdiff < -34'sh8000_0000) ? 32'sh8000_0000 : 32'(cdiff);
         rsp_radius_first  <= (act_ff == vsc_pkg::ACT_QREV) ? rad_ff : tw;
         rsp_radius_second <= (act_ff == vsc_pkg::ACT_QREV) ? tw : rad_ff;
      end
   end

   always_comb begin
      stat.dot_neg   = prod_ff[0] + prod_ff[1] + prod_ff[2] < 0;
      stat.dots_left = walk_ff < count_ff;
      stat.far       = offm[0][31] | offm[1][31] | offm[2][31];
      stat.no_hit    = !(sumsq_ff < 64'(rad_ff) * 64'(rad_ff));
      stat.sqrt_last = bit_ff[1:0] != 2'b00 || bit_ff == '0;
      stat.div_last  = dcnt_ff == 7'(QW);
      stat.axis_last = axis_ff == 2'd2;
      stat.flat      = flat_ff;
      stat.action    = act_ff;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(vsc_pkg::MaxNormals))
      else $error("normal count beyond capacity");
   assert property (@(posedge clock) disable iff (reset) cmd.clear_store |=> count_ff == '0)
      else $error("clear did not empty store");
   assert property (@(posedge clock) disable iff (reset) !(cmd.emit && cmd.emit_zero))
      else $error("both result kinds at once");
endmodule
`default_nettype wire

// ===== design/vsc_control.sv =====
// Controller state machine sequencing the datapath.
`default_nettype none
module vsc_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rsp_valid,
   output vsc_pkg::cmd_type       cmd,
   input  wire vsc_pkg::stat_type stat
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_DOTRD, S_DOTMUL, S_DOTCHK, S_SQ, S_HITCHK,
      S_SQRT, S_DIVINIT, S_DIV, S_CP, S_EMIT, S_ZERO
   } state_type;

   state_type state_ff;

   always_comb begin
      cmd = '0;
      cmd.capture     = state_ff == S_IDLE && start;
      cmd.load_store  = state_ff == S_DECODE && stat.action == vsc_pkg::ACT_LOAD;
      cmd.clear_store = state_ff == S_DECODE && stat.action == vsc_pkg::ACT_CLEAR;
      cmd.dot_step    = state_ff == S_DOTRD && stat.dots_left;
      cmd.dot_check   = state_ff == S_DOTCHK;
      cmd.sq_step     = state_ff == S_SQ;
      cmd.sqrt_init   = state_ff == S_HITCHK;
      cmd.sqrt_step   = state_ff == S_SQRT;
      cmd.div_init    = state_ff == S_DIVINIT;
      cmd.div_step    = state_ff == S_DIV && !stat.div_last;
      cmd.div_done    = state_ff == S_DIV && stat.div_last;
      cmd.cp_step     = state_ff == S_CP;
      cmd.emit        = state_ff == S_EMIT;
      cmd.emit_zero   = state_ff == S_ZERO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy      <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit || cmd.emit_zero;
         unique case (state_ff)
            S_IDLE:    if (start) begin state_ff <= S_DECODE; busy <= 1'b1; end
            S_DECODE:  if (stat.action == vsc_pkg::ACT_LOAD || stat.action == vsc_pkg::ACT_CLEAR
                           || stat.flat) state_ff <= S_ZERO;
                       else state_ff <= S_DOTRD;
            S_DOTRD:   state_ff <= stat.dots_left ? S_DOTMUL : (stat.far ? S_ZERO : S_SQ);
            S_DOTMUL:  state_ff <= S_DOTCHK;
            S_DOTCHK:  state_ff <= stat.dot_neg ? S_ZERO : S_DOTRD;
            S_SQ:      if (stat.axis_last) state_ff <= S_HITCHK;
            S_HITCHK:  state_ff <= stat.no_hit ? S_ZERO : S_SQRT;
            S_SQRT:    if (stat.sqrt_last) state_ff <= S_DIVINIT;
            S_DIVINIT: state_ff <= S_DIV;
            S_DIV:     if (stat.div_last && stat.axis_last) state_ff <= S_CP;
            S_CP:      if (stat.axis_last) state_ff <= S_EMIT;
            S_EMIT:    begin state_ff <= S_IDLE; busy <= 1'b0; end
            S_ZERO:    begin state_ff <= S_IDLE; busy <= 1'b0; end
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy == 1'b0)
      else $error("result while busy");
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted beat not taken");
   assert property (@(posedge clock) disable iff (reset) $fell(busy) |-> rsp_valid)
      else $error("beat finished without result");
endmodule
`default_nettype wire

// ===== design/vertex_sphere_contact_geometry_unit.sv =====
// Top level of the vertex-sphere contact unit.
`default_nettype none
// Command-style block: a beat is taken when start is high and busy low; one
// result beat per command appears for a single cycle on rsp_valid and cannot
// be stalled. Loads and clears stay busy for decode and a zero-result state,
// with the result in the cycle after. A query stays busy for decode, a read,
// multiply and sign check per stored normal, the squared distance, the range
// check, the bit-pair square root, the restoring divider that normalizes the
// offset (48 quotient bits and a writeback per axis), the contact
// products and the emit state, with the result in the cycle after; the shared
// divider dominates. A flat vertex, far offset, negative dot or miss ends early
// with a zero result. Loads past eight normals are dropped.
module vertex_sphere_contact_geometry_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_vertex_x,
   input  wire logic signed [31:0] req_vertex_y,
   input  wire logic signed [31:0] req_vertex_z,
   input  wire logic signed [31:0] req_sphere_x,
   input  wire logic signed [31:0] req_sphere_y,
   input  wire logic signed [31:0] req_sphere_z,
   input  wire logic [30:0]        req_sphere_radius,
   input  wire logic               req_vertex_flat,
   input  wire logic signed [31:0] req_face_normal_x,
   input  wire logic signed [31:0] req_face_normal_y,
   input  wire logic signed [31:0] req_face_normal_z,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic signed [31:0]      rsp_unit_normal_x,
   output logic signed [31:0]      rsp_unit_normal_y,
   output logic signed [31:0]      rsp_unit_normal_z,
   output logic [30:0]             rsp_depth,
   output logic signed [31:0]      rsp_contact_x,
   output logic signed [31:0]      rsp_contact_y,
   output logic signed [31:0]      rsp_contact_z,
   output logic [30:0]             rsp_radius_first,
   output logic [30:0]             rsp_radius_second
);
   vsc_pkg::cmd_type  cmd;
   vsc_pkg::stat_type stat;

   vsc_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .cmd(cmd), .stat(stat)
   );

   vsc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_action(req_action),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z),
      .req_sphere_x(req_sphere_x), .req_sphere_y(req_sphere_y),
      .req_sphere_z(req_sphere_z),
      .req_sphere_radius(req_sphere_radius), .req_vertex_flat(req_vertex_flat),
      .req_face_normal_x(req_face_normal_x), .req_face_normal_y(req_face_normal_y),
      .req_face_normal_z(req_face_normal_z),
      .rsp_hit(rsp_hit),
      .rsp_unit_normal_x(rsp_unit_normal_x), .rsp_unit_normal_y(rsp_unit_normal_y),
      .rsp_unit_normal_z(rsp_unit_normal_z),
      .rsp_depth(rsp_depth),
      .rsp_contact_x(rsp_contact_x), .rsp_contact_y(rsp_contact_y),
      .rsp_contact_z(rsp_contact_z),
      .rsp_radius_first(rsp_radius_first), .rsp_radius_second(rsp_radius_second)
   );
endmodule
`default_nettype wire
